@@ rtl/bcc_pkg.sv @@
package bcc_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_TARGET_ANGLE = 3'd0;
    localparam logic [2:0] REG_UPRIGHT_KP   = 3'd1;
    localparam logic [2:0] REG_UPRIGHT_KD   = 3'd2;
    localparam logic [2:0] REG_SPEED_KP     = 3'd3;
    localparam logic [2:0] REG_SPEED_KI     = 3'd4;
    localparam logic [2:0] REG_YAW_KP       = 3'd5;
    localparam logic [2:0] REG_PWM_LIMIT    = 3'd6;

    localparam logic signed [16:0] RST_TARGET_ANGLE = 17'sd0;
    localparam logic signed [31:0] RST_UPRIGHT_KP   = -32'sd12976128;
    localparam logic signed [31:0] RST_UPRIGHT_KD   = -32'sd31457;
    localparam logic signed [31:0] RST_SPEED_KP     = -32'sd32768;
    localparam logic signed [31:0] RST_SPEED_KI     = -32'sd164;
    localparam logic signed [31:0] RST_YAW_KP       = -32'sd52429;
    localparam logic [14:0]        RST_PWM_LIMIT    = 15'd7200;

    typedef struct packed {
        logic signed [16:0] target_angle;
        logic signed [31:0] upright_kp;
        logic signed [31:0] upright_kd;
        logic signed [31:0] speed_kp;
        logic signed [31:0] speed_ki;
        logic signed [31:0] yaw_kp;
        logic [14:0]        pwm_limit;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_FX, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_OUT
    } t_state;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MUL_NONE, MUL_UP_P, MUL_DIV, MUL_UP_D, MUL_SPD_P, MUL_SPD_I, MUL_TURN, MUL_COMMON
    } t_mul;

    // what is done with the product registered in the previous cycle
    typedef enum logic [2:0] {
        OP_NONE, OP_UP_P, OP_FILT, OP_UP_D, OP_SPD_P, OP_SPD_I, OP_TURN, OP_COMMON
    } t_op;

    typedef struct packed {
        logic load_in;
        logic calc_fx;
        logic calc_integ;
        t_mul mul;
        t_op  op;
        logic out_write;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

@@ rtl/bcc_regs.sv @@
module bcc_regs
    import bcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle <= RST_TARGET_ANGLE;
            r_cfg.upright_kp   <= RST_UPRIGHT_KP;
            r_cfg.upright_kd   <= RST_UPRIGHT_KD;
            r_cfg.speed_kp     <= RST_SPEED_KP;
            r_cfg.speed_ki     <= RST_SPEED_KI;
            r_cfg.yaw_kp       <= RST_YAW_KP;
            r_cfg.pwm_limit    <= RST_PWM_LIMIT;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_TARGET_ANGLE: r_cfg.target_angle <= pwdata[16:0];
                REG_UPRIGHT_KP:   r_cfg.upright_kp   <= pwdata;
                REG_UPRIGHT_KD:   r_cfg.upright_kd   <= pwdata;
                REG_SPEED_KP:     r_cfg.speed_kp     <= pwdata;
                REG_SPEED_KI:     r_cfg.speed_ki     <= pwdata;
                REG_YAW_KP:       r_cfg.yaw_kp       <= pwdata;
                REG_PWM_LIMIT:    r_cfg.pwm_limit    <= pwdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TARGET_ANGLE: prdata = {15'd0, r_cfg.target_angle};
            REG_UPRIGHT_KP:   prdata = r_cfg.upright_kp;
            REG_UPRIGHT_KD:   prdata = r_cfg.upright_kd;
            REG_SPEED_KP:     prdata = r_cfg.speed_kp;
            REG_SPEED_KI:     prdata = r_cfg.speed_ki;
            REG_YAW_KP:       prdata = r_cfg.yaw_kp;
            REG_PWM_LIMIT:    prdata = {17'd0, r_cfg.pwm_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

@@ rtl/bcc_ctrl.sv @@
module bcc_ctrl
    import bcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{load_in: 1'b0, calc_fx: 1'b0, calc_integ: 1'b0,
                       mul: MUL_NONE, op: OP_NONE, out_write: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_FX;
                end
            end
            S_FX: begin
                o_cmd.calc_fx = 1'b1;
                o_cmd.mul     = MUL_UP_P;
                n_state       = S_M1;
            end
            S_M1: begin
                o_cmd.mul = MUL_DIV;
                o_cmd.op  = OP_UP_P;
                n_state   = S_M2;
            end
            S_M2: begin
                o_cmd.mul = MUL_UP_D;
                o_cmd.op  = OP_FILT;
                n_state   = S_M3;
            end
            S_M3: begin
                o_cmd.mul        = MUL_SPD_P;
                o_cmd.op         = OP_UP_D;
                o_cmd.calc_integ = 1'b1;
                n_state          = S_M4;
            end
            S_M4: begin
                o_cmd.mul = MUL_SPD_I;
                o_cmd.op  = OP_SPD_P;
                n_state   = S_M5;
            end
            S_M5: begin
                o_cmd.mul = MUL_TURN;
                o_cmd.op  = OP_SPD_I;
                n_state   = S_M6;
            end
            S_M6: begin
                o_cmd.mul = MUL_COMMON;
                o_cmd.op  = OP_TURN;
                n_state   = S_M7;
            end
            S_M7: begin
                o_cmd.op = OP_COMMON;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_write = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/bcc_dp.sv @@
module bcc_dp
    import bcc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [16:0] i_pitch_angle,
    input  logic signed [15:0] i_pitch_rate,
    input  logic signed [15:0] i_yaw_rate,
    input  logic signed [15:0] i_left_ticks,
    input  logic signed [15:0] i_right_ticks,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_left_drive,
    output logic signed [15:0] o_right_drive
);

    // ceil(2^25 / 10): exact floor(n / 10) for n below 2^21
    localparam logic signed [31:0] DIV10_MAGIC = 32'sd3355444;
    localparam int unsigned        DIV10_SHIFT = 25;
    localparam logic signed [14:0] INTEG_LIM   = 15'sd10000;

    // divide by 2^n, rounding toward zero
    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] p,
                                                     input int unsigned n);
        logic signed [63:0] bias;
        bias = (64'sd1 <<< n) - 64'sd1;
        if (p < 0) begin
            return (p + bias) >>> n;
        end
        return p >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        if (v > 49'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -49'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // latched sample
    logic signed [16:0] r_angle;
    logic signed [15:0] r_prate;
    logic signed [15:0] r_yrate;
    logic signed [15:0] r_lt;
    logic signed [15:0] r_rt;

    // loop state
    logic signed [17:0] r_fse;
    logic signed [14:0] r_si;

    // work registers
    logic signed [21:0] r_fx;
    logic signed [63:0] r_prod;
    logic signed [17:0] r_filt;
    logic signed [14:0] r_integ;
    logic signed [33:0] r_up;
    logic signed [35:0] r_spd;
    logic signed [31:0] r_turn;
    logic signed [48:0] r_common;

    logic               r_out_valid;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;

    logic signed [17:0] w_err;
    logic signed [16:0] w_sum;
    logic signed [21:0] w_fx;
    logic [21:0]        w_fx_abs;
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [63:0] w_t16;
    logic signed [63:0] w_t24;
    logic [17:0]        w_quot;
    logic signed [17:0] w_filt;
    logic signed [18:0] w_isum;
    logic signed [14:0] w_integ;
    logic signed [49:0] w_left;
    logic signed [49:0] w_right;
    logic signed [49:0] w_lim;
    logic signed [15:0] w_left_c;
    logic signed [15:0] w_right_c;

    assign w_err = 18'(r_angle) - 18'(i_cfg.target_angle);
    assign w_sum = 17'(r_rt) - 17'(r_lt);
    // 3*sum + 7*filtered
    assign w_fx  = 22'(w_sum) + (22'(w_sum) <<< 1) + (22'(r_fse) <<< 3) - 22'(r_fse);
    assign w_fx_abs = r_fx[21] ? 22'(-r_fx) : r_fx;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.mul)
            MUL_NONE: begin
            end
            MUL_UP_P: begin
                w_mul_a = i_cfg.upright_kp;
                w_mul_b = 32'(w_err);
            end
            MUL_DIV: begin
                w_mul_a = DIV10_MAGIC;
                w_mul_b = {10'd0, w_fx_abs};
            end
            MUL_UP_D: begin
                w_mul_a = i_cfg.upright_kd;
                w_mul_b = 32'(r_prate);
            end
            MUL_SPD_P: begin
                w_mul_a = i_cfg.speed_kp;
                w_mul_b = 32'(r_filt);
            end
            MUL_SPD_I: begin
                w_mul_a = i_cfg.speed_ki;
                w_mul_b = 32'(r_integ);
            end
            MUL_TURN: begin
                w_mul_a = i_cfg.yaw_kp;
                w_mul_b = 32'(r_yrate);
            end
            MUL_COMMON: begin
                w_mul_a = i_cfg.upright_kp;
                w_mul_b = sat32(49'(r_spd));
            end
            default: begin
            end
        endcase
    end

    assign w_t16  = trunc_shr(r_prod, 16);
    assign w_t24  = trunc_shr(r_prod, 24);
    assign w_quot = r_prod[DIV10_SHIFT+17:DIV10_SHIFT];
    assign w_filt = r_fx[21] ? -$signed(w_quot) : $signed(w_quot);

    assign w_isum  = 19'(r_si) + 19'(r_filt);
    assign w_integ = (w_isum > 19'(INTEG_LIM))  ? INTEG_LIM :
                     (w_isum < -19'(INTEG_LIM)) ? -INTEG_LIM : w_isum[14:0];

    assign w_lim   = $signed({35'd0, i_cfg.pwm_limit});
    assign w_left  = 50'(r_common) - 50'(r_turn);
    assign w_right = 50'(r_common) + 50'(r_turn);
    assign w_left_c  = (w_left > w_lim)   ? w_lim[15:0] :
                       (w_left < -w_lim)  ? 16'(-w_lim) : w_left[15:0];
    assign w_right_c = (w_right > w_lim)  ? w_lim[15:0] :
                       (w_right < -w_lim) ? 16'(-w_lim) : w_right[15:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_angle <= i_pitch_angle;
            r_prate <= i_pitch_rate;
            r_yrate <= i_yaw_rate;
            r_lt    <= i_left_ticks;
            r_rt    <= i_right_ticks;
        end
        if (i_cmd.calc_fx) begin
            r_fx <= w_fx;
        end
        r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.calc_integ) begin
            r_integ <= w_integ;
        end
        unique case (i_cmd.op)
            OP_NONE:   begin
            end
            OP_UP_P:   r_up     <= w_t24[33:0];
            OP_FILT:   r_filt   <= w_filt;
            OP_UP_D:   r_up     <= r_up + w_t16[33:0];
            OP_SPD_P:  r_spd    <= w_t16[35:0];
            OP_SPD_I:  r_spd    <= r_spd + w_t16[35:0];
            OP_TURN:   r_turn   <= w_t16[31:0];
            OP_COMMON: r_common <= 49'(sat32(49'(r_up))) - w_t16[48:0];
            default:   begin
            end
        endcase
        if (i_cmd.out_write) begin
            r_left  <= w_left_c;
            r_right <= w_right_c;
        end
    end

    // loop state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fse       <= '0;
            r_si        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_FILT) begin
                r_fse <= w_filt;
            end
            if (i_cmd.calc_integ) begin
                r_si <= w_integ;
            end
            if (i_cmd.out_write) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

endmodule

@@ rtl/balance_cascade_controller.sv @@
// Cascade balance controller: upright PD, speed PI, turn P, one drive pair per sample.
// Input channel (i_in_valid / o_in_ready): one request per control period holding
//   pitch angle, pitch rate, yaw rate and both encoder deltas.
// Output channel (o_out_valid / i_out_ready): one request per input with the
//   left and right drive values, each clamped to +/- pwm_limit.
// Config: APB-style write/read port, register i at byte address 4*i; pready is
//   tied high. Write only while no sample is in flight.
// Schedule: the work runs through one shared 32x32 multiplier, seven products in a
//   row, one product a cycle with the product register consumed in the following
//   cycle.
// Acceptance: a new sample is taken only once the previous one has left the last step.
// Stall: the result sits in an output register; the next sample is accepted and
//   worked on meanwhile, and its result waits in the last step until the output
//   register is taken.
// Reset (synchronous, active low): config registers go to their defaults, the
//   speed filter and the speed integral go to zero, both channels go empty.
module balance_cascade_controller
    import bcc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // sample in
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [16:0]  i_pitch_angle,
    input  logic signed [15:0]  i_pitch_rate,
    input  logic signed [15:0]  i_yaw_rate,
    input  logic signed [15:0]  i_left_ticks,
    input  logic signed [15:0]  i_right_ticks,
    // drives out
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_left_drive,
    output logic signed [15:0]  o_right_drive
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    // gains, setpoint and limit
    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: steps the shared multiplier through the loop terms
    bcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // arithmetic, loop state and output register
    bcc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_pitch_angle (i_pitch_angle),
        .i_pitch_rate  (i_pitch_rate),
        .i_yaw_rate    (i_yaw_rate),
        .i_left_ticks  (i_left_ticks),
        .i_right_ticks (i_right_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_drive  (o_left_drive),
        .o_right_drive (o_right_drive)
    );

    // after an accept, still busy when the sequence reaches the output step
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##9 !o_in_ready)
        else $error("input accepted again before the computation finished");

    // a new result is only written from the last step, which leaves to idle
    a_result_from_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared outside the output step");

    // drives stay inside the configured limit
    a_drive_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ($signed(o_left_drive)  <= $signed({1'b0, w_cfg.pwm_limit})) &&
            ($signed(o_left_drive)  >= -$signed({1'b0, w_cfg.pwm_limit})) &&
            ($signed(o_right_drive) <= $signed({1'b0, w_cfg.pwm_limit})) &&
            ($signed(o_right_drive) >= -$signed({1'b0, w_cfg.pwm_limit})))
        else $error("drive outside pwm limit");

endmodule
